// ===== src/tth_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tth_pkg;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHADE_ENABLE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ELEVATION_MAX = 2'd3;

  localparam int IMG_W_W  = 11;
  localparam int IMG_H_W  = 16;
  localparam int EMAX_W   = 15;

  localparam int DIV_N     = 42;
  localparam int DIV_D     = 25;
  localparam int DIV_CNT_W = $clog2(DIV_N + 1);

  localparam int SQ_IN_W    = 50;
  localparam int SQ_OUT_W   = 25;
  localparam int SQ_CNT_W   = $clog2(SQ_OUT_W + 1);

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] elevation;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pix_out_t;

endpackage

`default_nettype wire

// ===== src/tth_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tth_div
  import tth_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_N-1:0] dividend_i,
  input  wire logic [DIV_D-1:0] divisor_i,
  output logic                  done_o,
  output logic [DIV_N-1:0]      quotient_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_D-1:0]     rem_q;
  logic [DIV_N-1:0]     quo_q;
  logic [DIV_D-1:0]     dsr_q;

  logic [DIV_D:0] shifted;
  logic [DIV_D:0] diff;
  logic           ge;

  assign shifted = {rem_q, quo_q[DIV_N-1]};
  assign ge      = shifted >= {1'b0, dsr_q};
  assign diff    = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_N - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_D-1:0] : shifted[DIV_D-1:0];
      quo_q <= {quo_q[DIV_N-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== src/tth_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tth_isqrt
  import tth_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [SQ_IN_W-1:0]  radicand_i,
  output logic                     done_o,
  output logic [SQ_OUT_W-1:0]      root_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [SQ_CNT_W-1:0]  cnt_q;
  logic [SQ_IN_W-1:0]   x_q;
  logic [SQ_OUT_W+1:0]  rem_q;
  logic [SQ_OUT_W-1:0]  root_q;

  logic [SQ_OUT_W+3:0] shifted;
  logic [SQ_OUT_W+3:0] trial;
  logic [SQ_OUT_W+3:0] diff;
  logic                ge;

  assign shifted = {rem_q, x_q[SQ_IN_W-1 -: 2]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = shifted >= trial;
  assign diff    = shifted - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + SQ_CNT_W'(1);
      if (cnt_q == SQ_CNT_W'(SQ_OUT_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[SQ_IN_W-3:0], 2'b00};
      rem_q  <= ge ? diff[SQ_OUT_W+1:0] : shifted[SQ_OUT_W+1:0];
      root_q <= {root_q[SQ_OUT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

// ===== src/terrain_tint_hillshade.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Elevation-to-RGB colorizer with optional hillshade. Samples arrive in raster
// order; each push of row r emits the pixel of row r-1 at the same column, and
// drain transactions flush the final row, the last one flagged with last. Two
// row lines share one memory read at one address per cycle, so a transaction
// first fetches its center, left, right and upper neighbors one after another
// and then writes back. Ocean depth is scaled by a reciprocal product; the land
// ramp runs through a serial divider that yields one quotient bit per cycle
// (skipped at or above the ramp maximum) and, for shaded land, a serial square
// root followed by a second divide when the shade numerator is positive. A
// dropped transaction and a first-row push produce no pixel; a stalled output
// register holds a finished pixel back. Input stays stalled until the current
// transaction has written back or, if it yields a pixel, until that pixel is in
// the output register; a held result does not block the next fetch.
module terrain_tint_hillshade
  import tth_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire pix_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output pix_out_t                   out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int CW  = (WCW > IMG_W_W) ? WCW : IMG_W_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_COMMIT, ST_FRAC, ST_FRAC_WAIT, ST_RAMP, ST_GRAD, ST_SQ,
    ST_SQRT_GO, ST_SQRT_WAIT, ST_SH_GO, ST_SH_WAIT, ST_KMUL, ST_SHADE, ST_OUT
  } state_e;

  function automatic logic [16:0] rmul(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] p;
    p = a * b + 34'd32768;
    return p[32:16];
  endfunction

  function automatic logic [7:0] to_byte(input logic [16:0] c);
    logic [16:0] cc;
    logic [24:0] p;
    cc = (c > 17'd65536) ? 17'd65536 : c;
    p  = 25'(cc) * 25'd255 + 25'd32768;
    return p[23:16];
  endfunction

  // configuration
  logic [IMG_W_W-1:0] width_q;
  logic [IMG_H_W-1:0] height_q;
  logic               shade_q;
  logic [EMAX_W-1:0]  emax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= IMG_W_W'(1);
      height_q <= IMG_H_W'(1);
      shade_q  <= 1'b0;
      emax_q   <= EMAX_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:   width_q  <= cfg_data_i[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT:  height_q <= cfg_data_i[IMG_H_W-1:0];
        REG_SHADE_ENABLE:  shade_q  <= cfg_data_i[0];
        REG_ELEVATION_MAX: emax_q   <= cfg_data_i[EMAX_W-1:0];
        default: ;
      endcase
    end
  end

  state_e             state_q;
  logic [2:0]         cnt_q;
  logic [AW-1:0]      col_q;
  logic [IMG_H_W-1:0] row_q;
  logic               sel_q;
  logic               out_valid_q;
  pix_out_t           out_data_q;

  logic               op_q;
  logic [15:0]        cur_q;
  logic [AW-1:0]      c_q;
  logic               wend_q;
  logic               produce_q;
  logic               row1_q;
  logic               last_q;

  logic signed [15:0] centre_q, lf_q, rt_q, up_q, dn_q;
  logic [16:0]        frac_q;
  logic [16:0]        ch0_q, ch1_q, ch2_q;
  logic signed [16:0] gx_q, gy_q;
  logic [33:0]        sq_q;
  logic signed [34:0] num_q;
  logic [SQ_OUT_W-1:0] den_q;
  logic [16:0]        sh_q;
  logic [16:0]        k_q;

  // effective geometry
  logic [CW-1:0]      w_ext;
  logic [CW-1:0]      w_clamp;
  logic [WCW-1:0]     w_eff;
  logic [WCW-1:0]     wm1_full;
  logic [AW-1:0]      wm1;
  logic [AW-1:0]      c_sel;
  logic               wend;
  logic [IMG_H_W-1:0] h_eff;
  logic [EMAX_W-1:0]  emax_eff;

  assign w_ext    = CW'(width_q);
  assign w_clamp  = (width_q == '0) ? CW'(1) :
                    ((w_ext > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : w_ext);
  assign w_eff    = w_clamp[WCW-1:0];
  assign wm1_full = w_eff - WCW'(1);
  assign wm1      = wm1_full[AW-1:0];
  assign c_sel    = (WCW'(col_q) >= w_eff) ? wm1 : col_q;
  assign wend     = (c_sel == wm1);
  assign h_eff    = (height_q == '0) ? IMG_H_W'(1) : height_q;
  assign emax_eff = (emax_q == '0) ? EMAX_W'(1) : emax_q;

  logic accept;
  logic take;
  logic push_ok;
  logic drain_ok;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_ok    = (in_data_i.opcode == OP_PUSH) && (row_q < h_eff);
  assign drain_ok   = (in_data_i.opcode == OP_DRAIN) && (row_q >= h_eff) && (row_q != '0);
  assign take       = accept && (push_ok || drain_ok);

  // line memory: bank sel_q holds the previous row, the other bank the row before
  logic [15:0]   mem [2**(AW+1)];
  logic [AW:0]   rd_addr;
  logic [15:0]   rd_q;
  logic          mem_we;
  logic [AW-1:0] lf_idx;
  logic [AW-1:0] rt_idx;

  assign lf_idx = (c_q == '0) ? '0 : c_q - AW'(1);
  assign rt_idx = wend_q ? c_q : c_q + AW'(1);
  assign mem_we = (state_q == ST_COMMIT) && (op_q == OP_PUSH);

  always_comb begin
    case (cnt_q)
      3'd0:    rd_addr = {sel_q, c_q};
      3'd1:    rd_addr = {sel_q, lf_idx};
      3'd2:    rd_addr = {sel_q, rt_idx};
      3'd3:    rd_addr = {~sel_q, c_q};
      default: rd_addr = {sel_q, c_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[{~sel_q, c_q}] <= cur_q;
    end
    rd_q <= mem[rd_addr];
  end

  // arithmetic units
  logic               land;
  logic               land_full;
  logic signed [15:0] neg_c;
  logic [11:0]        depth;
  logic [22:0]        depth_scaled;
  logic [46:0]        depth_prod;
  logic [16:0]        depth_frac;
  logic               div_start;
  logic [DIV_N-1:0]   div_dividend;
  logic [DIV_D-1:0]   div_divisor;
  logic               div_done;
  logic [DIV_N-1:0]   div_quo;
  logic               sq_start;
  logic               sq_done;
  logic [SQ_OUT_W-1:0] sq_root;
  logic               num_pos;

  assign land      = centre_q > 16'sd0;
  assign land_full = land && (centre_q[14:0] >= emax_eff);
  assign neg_c     = 16'sd0 - centre_q;
  assign depth     = (centre_q < -16'sd4000) ? 12'd4000 : neg_c[11:0];
  assign num_pos   = !num_q[34] && (num_q != '0);

  // (depth * 65536 + 2000) / 4000 equals (depth * 2048 + 62) / 125
  assign depth_scaled = {depth, 11'd0} + 23'd62;
  assign depth_prod   = 47'(depth_scaled) * 47'd8589935;
  assign depth_frac   = depth_prod[46:30];

  always_comb begin
    div_start    = 1'b0;
    div_dividend = DIV_N'({centre_q[14:0], 16'h0000}) + DIV_N'(emax_eff[EMAX_W-1:1]);
    div_divisor  = DIV_D'(emax_eff);
    if (state_q == ST_FRAC) begin
      div_start = land && !land_full;
    end else if (state_q == ST_SH_GO) begin
      div_start    = 1'b1;
      div_dividend = DIV_N'({num_q[31:0], 8'h00}) + DIV_N'(den_q[SQ_OUT_W-1:1]);
      div_divisor  = DIV_D'(den_q);
    end
  end

  assign sq_start = (state_q == ST_SQRT_GO);

  tth_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  tth_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i ({sq_q, 16'h0000}),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  // ramp and shade products
  logic        seg_hi;
  logic [17:0] k2;
  logic [16:0] kr;
  logic [16:0] r0, r1, r2;
  logic signed [17:0] gsum;
  logic signed [34:0] gsum_w;
  logic signed [33:0] gxx, gyy;

  assign seg_hi = frac_q >= 17'd32768;
  assign k2     = {frac_q, 1'b0} - (seg_hi ? 18'd65536 : 18'd0);
  assign kr     = k2[16:0];

  always_comb begin
    if (!land) begin
      r0 = 17'd6554  - rmul(17'd3932,  frac_q);
      r1 = 17'd18350 - rmul(17'd11796, frac_q);
      r2 = 17'd36045 - rmul(17'd13107, frac_q);
    end else if (!seg_hi) begin
      r0 = 17'd16384 + rmul(17'd22938, kr);
      r1 = 17'd36045 - rmul(17'd6554,  kr);
      r2 = 17'd13107 + rmul(17'd3277,  kr);
    end else begin
      r0 = 17'd39322 + rmul(17'd26214, kr);
      r1 = 17'd29491 + rmul(17'd36045, kr);
      r2 = 17'd16384 + rmul(17'd49152, kr);
    end
  end

  assign gsum   = 18'(gx_q) + 18'(gy_q);
  assign gsum_w = 35'(gsum);
  assign gxx    = gx_q * gx_q;
  assign gyy    = gy_q * gy_q;

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q      <= in_data_i.opcode;
      cur_q     <= in_data_i.elevation;
      c_q       <= c_sel;
      wend_q    <= wend;
      produce_q <= (in_data_i.opcode == OP_DRAIN) || (row_q != '0);
      row1_q    <= (row_q == IMG_H_W'(1));
      last_q    <= (in_data_i.opcode == OP_DRAIN) && wend;
    end
    case (state_q)
      ST_READ: begin
        case (cnt_q)
          3'd1:    centre_q <= rd_q;
          3'd2:    lf_q     <= rd_q;
          3'd3:    rt_q     <= rd_q;
          3'd4:    up_q     <= rd_q;
          default: ;
        endcase
      end
      ST_COMMIT: begin
        if (row1_q) begin
          up_q <= centre_q;
        end
        dn_q <= (op_q == OP_PUSH) ? cur_q : centre_q;
      end
      ST_FRAC: begin
        if (!land) begin
          frac_q <= depth_frac;
        end else if (land_full) begin
          frac_q <= 17'd65536;
        end
      end
      ST_FRAC_WAIT: begin
        if (div_done) begin
          frac_q <= div_quo[16:0];
        end
      end
      ST_RAMP: begin
        ch0_q <= r0;
        ch1_q <= r1;
        ch2_q <= r2;
      end
      ST_GRAD: begin
        gx_q <= 17'(rt_q) - 17'(lf_q);
        gy_q <= 17'(dn_q) - 17'(up_q);
      end
      ST_SQ: begin
        sq_q  <= 34'(gxx) + 34'(gyy) + 34'd3600;
        num_q <= gsum_w * 35'sd29308 + 35'sd3045840;
      end
      ST_SQRT_WAIT: begin
        if (sq_done) begin
          den_q <= sq_root;
          sh_q  <= '0;
        end
      end
      ST_SH_WAIT: begin
        if (div_done) begin
          sh_q <= (div_quo > DIV_N'(65536)) ? 17'd65536 : div_quo[16:0];
        end
      end
      ST_KMUL: begin
        k_q <= 17'd29491 + rmul(17'd55706, sh_q);
      end
      ST_SHADE: begin
        ch0_q <= rmul(ch0_q, k_q);
        ch1_q <= rmul(ch1_q, k_q);
        ch2_q <= rmul(ch2_q, k_q);
      end
      default: ;
    endcase
  end

  logic out_load;

  assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);

  // sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      col_q       <= '0;
      row_q       <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q      <= 1'b1;
        out_data_q.red   <= to_byte(ch0_q);
        out_data_q.green <= to_byte(ch1_q);
        out_data_q.blue  <= to_byte(ch2_q);
        out_data_q.last  <= last_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (take) begin
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd4) begin
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (op_q == OP_PUSH) begin
            if (wend_q) begin
              col_q <= '0;
              row_q <= row_q + IMG_H_W'(1);
              sel_q <= ~sel_q;
            end else begin
              col_q <= c_q + AW'(1);
            end
          end else if (last_q) begin
            col_q <= '0;
            row_q <= '0;
          end else begin
            col_q <= c_q + AW'(1);
          end
          state_q <= produce_q ? ST_FRAC : ST_IDLE;
        end
        ST_FRAC: begin
          state_q <= (land && !land_full) ? ST_FRAC_WAIT : ST_RAMP;
        end
        ST_FRAC_WAIT: begin
          if (div_done) begin
            state_q <= ST_RAMP;
          end
        end
        ST_RAMP: begin
          state_q <= (land && shade_q) ? ST_GRAD : ST_OUT;
        end
        ST_GRAD: begin
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          state_q <= ST_SQRT_GO;
        end
        ST_SQRT_GO: begin
          state_q <= ST_SQRT_WAIT;
        end
        ST_SQRT_WAIT: begin
          if (sq_done) begin
            state_q <= num_pos ? ST_SH_GO : ST_KMUL;
          end
        end
        ST_SH_GO: begin
          state_q <= ST_SH_WAIT;
        end
        ST_SH_WAIT: begin
          if (div_done) begin
            state_q <= ST_KMUL;
          end
        end
        ST_KMUL: begin
          state_q <= ST_SHADE;
        end
        ST_SHADE: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_FRAC_WAIT || state_q == ST_SH_WAIT))
    else $error("divider finished outside a wait state");

  a_sqrt_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == ST_SQRT_WAIT)
    else $error("square root finished outside its wait state");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RAMP |-> frac_q <= 17'd65536)
    else $error("color ramp fraction above one");

  a_shade_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_KMUL |-> sh_q <= 17'd65536)
    else $error("shade factor above one");

  a_commit_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COMMIT |-> $past(state_q) == ST_READ && $past(cnt_q) == 3'd4)
    else $error("write-back without a complete neighbor fetch");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tth_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pix_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pix_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  terrain_tint_hillshade DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  localparam int LINE_DEPTH = 1024;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // shadow state of the colorizer
  logic signed [15:0] row_lines [2][LINE_DEPTH];
  bit mid_sel;
  int unsigned col_pos, row_pos;
  int unsigned width_cfg, height_cfg, shade_cfg, emax_cfg;

  pix_out_t expected_pixels[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic longint rnd_mul(longint a, longint b);
    return (a * b + 32768) >>> 16;
  endfunction

  function automatic logic [7:0] to_byte(longint c);
    if (c < 0) c = 0;
    if (c > 65536) c = 65536;
    return 8'((c * 255 + 32768) >>> 16);
  endfunction

  function automatic longint floor_sqrt(longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic pix_out_t color_pixel(int e, int lf, int rt, int up, int dn);
    longint ch[3];
    longint depth, d, emax, t, k, gx, gy, num, s, den, sh;
    pix_out_t px;
    if (e <= 0) begin
      depth = -e;
      if (depth > 4000) depth = 4000;
      d = (depth * 65536 + 2000) / 4000;
      ch[0] = 6554 - rnd_mul(3932, d);
      ch[1] = 18350 - rnd_mul(11796, d);
      ch[2] = 36045 - rnd_mul(13107, d);
    end else begin
      emax = (emax_cfg == 0) ? 1 : emax_cfg;
      t = (e >= emax) ? 65536 : ((longint'(e) * 65536 + emax / 2) / emax);
      if (t < 32768) begin
        k = 2 * t;
        ch[0] = 16384 + rnd_mul(22938, k);
        ch[1] = 36045 - rnd_mul(6554, k);
        ch[2] = 13107 + rnd_mul(3277, k);
      end else begin
        k = 2 * t - 65536;
        ch[0] = 39322 + rnd_mul(26214, k);
        ch[1] = 29491 + rnd_mul(36045, k);
        ch[2] = 16384 + rnd_mul(49152, k);
      end
      if (shade_cfg != 0) begin
        gx = longint'(rt) - lf;
        gy = longint'(dn) - up;
        num = 29308 * (gx + gy) + 50764 * 60;
        s = gx * gx + gy * gy + 3600;
        den = floor_sqrt(longint'(s) << 16);
        sh = 0;
        if (num > 0) begin
          sh = (num * 256 + den / 2) / den;
          if (sh > 65536) sh = 65536;
        end
        k = 29491 + rnd_mul(55706, sh);
        for (int i = 0; i < 3; i++) ch[i] = rnd_mul(ch[i], k);
      end
    end
    px.red = to_byte(ch[0]);
    px.green = to_byte(ch[1]);
    px.blue = to_byte(ch[2]);
    px.last = 1'b0;
    return px;
  endfunction

  task automatic predict_pixel(input pix_in_t it);
    int unsigned w, h, c;
    int centre, top, lf, rt;
    pix_out_t px;
    w = (width_cfg == 0) ? 1 : width_cfg;
    h = (height_cfg == 0) ? 1 : height_cfg;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    c = (col_pos >= w) ? w - 1 : col_pos;
    centre = row_lines[mid_sel][c];
    top = (row_pos == 1) ? centre : int'(row_lines[!mid_sel][c]);
    lf = row_lines[mid_sel][(c > 0) ? c - 1 : 0];
    rt = row_lines[mid_sel][(c + 1 < w) ? c + 1 : w - 1];
    if (it.opcode == OP_PUSH) begin
      if (row_pos >= h) return;
      if (row_pos >= 1) expected_pixels.push_back(color_pixel(centre, lf, rt, top,
                                                              int'(it.elevation)));
      row_lines[!mid_sel][c] = it.elevation;
      if (c + 1 >= w) begin
        mid_sel = !mid_sel;
        col_pos = 0;
        row_pos = (row_pos + 1) & 16'hFFFF;
      end else begin
        col_pos = c + 1;
      end
    end else begin
      if (row_pos < h || row_pos == 0) return;
      px = color_pixel(centre, lf, rt, top, centre);
      px.last = (c + 1 >= w);
      expected_pixels.push_back(px);
      if (px.last) begin
        col_pos = 0;
        row_pos = 0;
      end else begin
        col_pos = c + 1;
      end
    end
  endtask

  always @(posedge clk_i) begin
    pix_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel %h", $time, out_data_o);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (want.red !== out_data_o.red) begin
          $display("%0t: red exp %0d got %0d", $time, want.red, out_data_o.red);
          errors++;
        end
        if (want.green !== out_data_o.green) begin
          $display("%0t: green exp %0d got %0d", $time, want.green, out_data_o.green);
          errors++;
        end
        if (want.blue !== out_data_o.blue) begin
          $display("%0t: blue exp %0d got %0d", $time, want.blue, out_data_o.blue);
          errors++;
        end
        if (want.last !== out_data_o.last) begin
          $display("%0t: last exp %0d got %0d", $time, want.last, out_data_o.last);
          errors++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // called at a falling edge; returns at a falling edge
  task automatic send_sample(input logic op, input logic signed [15:0] elev);
    in_valid_i <= 1'b1;
    in_data_i <= '{opcode: op, elevation: elev};
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    predict_pixel(in_data_i);
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH: width_cfg = val & 32'h7FF;
      REG_IMAGE_HEIGHT: height_cfg = val & 32'hFFFF;
      REG_SHADE_ENABLE: shade_cfg = val & 1;
      default: emax_cfg = val & 32'h7FFF;
    endcase
  endtask

  task automatic setup_image(int unsigned w, int unsigned h, int unsigned sh,
                             int unsigned em);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_SHADE_ENABLE, sh);
    write_reg(REG_ELEVATION_MAX, em);
  endtask

  function automatic logic signed [15:0] rand_elevation(int prev);
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'sh7FFF;
      2: return 16'sh8000;
      3: return 16'($urandom_range(0, 8000) - 4000);
      default: return 16'(prev + int'($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  task automatic run_image(int unsigned w, int unsigned h, bit noise);
    int prev;
    prev = $urandom_range(0, 3000);
    for (int i = 0; i < w * h; i++) begin
      if (noise && $urandom_range(15) == 0) send_sample(OP_DRAIN, 16'($urandom));
      prev = rand_elevation(prev);
      send_sample(OP_PUSH, 16'(prev));
    end
    if (noise && $urandom_range(3) == 0) send_sample(OP_PUSH, 16'($urandom));
    for (int i = 0; i < w; i++) send_sample(OP_DRAIN, 16'($urandom));
  endtask

  task automatic test_color_extremes();
    logic signed [15:0] vals[9] = '{16'sh7FFF, 16'sh8000, 0, 1, -4000, -4001,
                                    16'sh7FFF, 16'sh8000, 2000};
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 0) setup_image(3, 3, 1, 32767);
      else setup_image(3, 3, 0, 1);
      foreach (vals[i]) send_sample(OP_PUSH, vals[i]);
      for (int i = 0; i < 3; i++) send_sample(OP_DRAIN, vals[i]);
    end
  endtask

  task automatic test_ignored_items();
    setup_image(1, 1, 1, 100);
    send_sample(OP_DRAIN, 16'sh1234);
    send_sample(OP_PUSH, 16'sd50);
    send_sample(OP_PUSH, 16'sd70);
    send_sample(OP_DRAIN, 16'sh0);
    send_sample(OP_DRAIN, 16'sh0);
  endtask

  task automatic test_width_lowered();
    setup_image(8, 2, 1, 500);
    for (int i = 0; i < 5; i++) send_sample(OP_PUSH, 16'(i * 90));
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, 4);
    run_image(4, 1, 0);
  endtask

  task automatic test_height_max();
    setup_image(4, 65535, 1, 1000);
    for (int i = 0; i < 12; i++) send_sample(OP_PUSH, 16'($urandom_range(0, 1500)));
    wait_drained();
    write_reg(REG_IMAGE_HEIGHT, 3);
    for (int i = 0; i < 4; i++) send_sample(OP_DRAIN, 16'sh0);
  endtask

  task automatic test_wide_row();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    setup_image(32, 1, 1, 4000);
    run_image(32, 1, 0);
  endtask

  task automatic test_random_images();
    int idle_tab[4] = '{0, 64, 0, 34};
    int stall_tab[4] = '{0, 0, 64, 34};
    int w, h, count;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      count = 0;
      while (count < 72) begin
        w = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        h = $urandom_range(1, 4);
        setup_image(w, h, $urandom_range(3) != 0,
                    ($urandom_range(5) == 0) ? $urandom_range(1, 32767)
                                             : $urandom_range(1, 4000));
        run_image(w, h, 1);
        count += w * (h + 1);
      end
    end
  endtask

  initial begin
    width_cfg = 1;
    height_cfg = 1;
    shade_cfg = 0;
    emax_cfg = 1;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_ignored_items();
    test_color_extremes();
    test_width_lowered();
    test_height_max();
    test_wide_row();
    test_random_images();
    wait_drained();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/tth_pkg.sv
src/tth_div.sv
src/tth_isqrt.sv
src/terrain_tint_hillshade.sv
sim/testbench.sv
